// ----- design/mbfp_pkg.sv -----
// shared types and constants for the metaball field potential block
`default_nettype none

package mbfp_pkg;

   localparam int MAX_CHARGES   = 16;
   localparam int IDX_W         = $clog2(MAX_CHARGES);
   localparam int CNT_W         = $clog2(MAX_CHARGES + 1);
   localparam int COORD_W       = 24;
   localparam int DIFF_W        = COORD_W + 1;
   localparam int SQ_W          = 2 * COORD_W + 1;
   localparam int D2_W          = SQ_W + 1;
   localparam int NUM_W         = 2 * COORD_W;
   localparam int BITS_PER_CELL = 2;
   localparam int NUM_CELLS     = NUM_W / BITS_PER_CELL;
   localparam int ACC_W         = 62;
   localparam int FIELD_W       = 40;
   localparam int ISO_W         = 32;
   localparam int ACTIVE_W      = 5;

   localparam logic [ACC_W-1:0] CLAMP_Q12 = ACC_W'(64'd409600000000);
   localparam logic [ACC_W-1:0] TERM_SAT  = ACC_W'(64'd72057594037927936);

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam logic CSR_THRESHOLD      = 1'b0;
   localparam logic CSR_ACTIVE_CHARGES = 1'b1;

   // one term in flight through the divider row
   typedef struct packed {
      logic             valid;
      logic             neg;
      logic             sat;
      logic [D2_W-1:0]  divisor;
      logic [D2_W-1:0]  rem;
      logic [NUM_W-1:0] num;
      logic [NUM_W-1:0] quo;
   } div_lane_type;

endpackage

`default_nettype wire

// ----- design/mbfp_div_cell.sv -----
// one cell of the divider row: two restoring quotient bits, then a register
`default_nettype none

module mbfp_div_cell
   import mbfp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire div_lane_type lane_in,
   output div_lane_type      lane_out
);

   div_lane_type lane_ff;
   div_lane_type lane_in_step;

   always_comb begin
      logic [D2_W:0]    trial;
      logic [D2_W-1:0]  rem_v;
      logic [NUM_W-1:0] num_v;
      logic [NUM_W-1:0] quo_v;
      rem_v = lane_in.rem;
      num_v = lane_in.num;
      quo_v = lane_in.quo;
      for (int k = 0; k < BITS_PER_CELL; k++) begin
         trial = {rem_v, num_v[NUM_W-1]};
         num_v = {num_v[NUM_W-2:0], 1'b0};
         if (trial >= {1'b0, lane_in.divisor}) begin
            rem_v = D2_W'(trial - {1'b0, lane_in.divisor});
            quo_v = {quo_v[NUM_W-2:0], 1'b1};
         end else begin
            rem_v = trial[D2_W-1:0];
            quo_v = {quo_v[NUM_W-2:0], 1'b0};
         end
      end
      lane_in_step     = lane_in;
      lane_in_step.rem = rem_v;
      lane_in_step.num = num_v;
      lane_in_step.quo = quo_v;
   end

   always_ff @(posedge clock) begin
      lane_ff.neg     <= lane_in_step.neg;
      lane_ff.sat     <= lane_in_step.sat;
      lane_ff.divisor <= lane_in_step.divisor;
      lane_ff.rem     <= lane_in_step.rem;
      lane_ff.num     <= lane_in_step.num;
      lane_ff.quo     <= lane_in_step.quo;
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else begin
         lane_ff.valid <= lane_in_step.valid;
      end
   end

   assign lane_out = lane_ff;

endmodule

`default_nettype wire

// ----- design/metaball_field_potential.sv -----
// top level of the metaball field potential block
`default_nettype none

// Keeps a table of up to 16 point charges (position and strength, Q12.12) and
// answers a query point with the sum of strength / squared distance over the
// first active_charges entries, minus the threshold register, clamped to +-1e8
// (Q.12). A load transfer writes one entry and is acknowledged with an all-zero
// result. Charges are issued one per cycle into a distance front end (three
// stages) and then through a row of 24 divider cells, each resolving two
// quotient bits and handing its term to the next cell every cycle. One item
// is worked on at a time; the next request transfer is taken while a finished
// result still waits on the response side. Table entries read before they were
// written give undefined terms.

module metaball_field_potential
   import mbfp_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic                      req_type,
   input  wire logic [IDX_W-1:0]          req_slot,
   input  wire logic signed [COORD_W-1:0] req_pos_x,
   input  wire logic signed [COORD_W-1:0] req_pos_y,
   input  wire logic signed [COORD_W-1:0] req_pos_z,
   input  wire logic signed [COORD_W-1:0] req_strength,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic signed [FIELD_W-1:0]      rsp_field_value,
   output logic                           rsp_is_query_result,
   output logic                           rsp_clamped,
   input  wire logic                      csr_write_enable,
   input  wire logic                      csr_index,
   input  wire logic [ISO_W-1:0]          csr_write_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   // configuration
   logic [ISO_W-1:0]    iso_ff;
   logic [ACTIVE_W-1:0] active_ff;

   // charge table
   logic [COORD_W-1:0] tab_x_ff [MAX_CHARGES];
   logic [COORD_W-1:0] tab_y_ff [MAX_CHARGES];
   logic [COORD_W-1:0] tab_z_ff [MAX_CHARGES];
   logic [COORD_W-1:0] tab_q_ff [MAX_CHARGES];

   // control
   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] n_lim_ff, n_lim_in;
   logic [CNT_W-1:0] iss_cnt_ff;
   logic [CNT_W-1:0] recv_cnt_ff;
   logic             req_xfer, rsp_free, issue, done_run;
   logic [COORD_W-1:0] pt_x_ff, pt_y_ff, pt_z_ff;

   // accumulator and pending result
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [FIELD_W-1:0] res_field_ff;
   logic                      res_query_ff, res_clamp_ff;
   logic                      rsp_valid_ff;
   logic signed [FIELD_W-1:0] rsp_field_ff;
   logic                      rsp_query_ff, rsp_clamp_ff;

   // distance front end
   logic                     s1_v_ff, s2_v_ff;
   logic signed [DIFF_W-1:0] dx_ff, dy_ff, dz_ff;
   logic signed [COORD_W-1:0] s1_q_ff, s2_q_ff;
   logic [SQ_W-1:0]          sqx_ff, sqy_ff, sqz_ff;
   logic signed [2*DIFF_W-1:0] px_prod, py_prod, pz_prod;
   div_lane_type             s3_lane_ff;

   // divider row
   div_lane_type lanes [NUM_CELLS+1];
   div_lane_type tail;
   logic signed [ACC_W-1:0] term;

   assign req_xfer = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign issue     = (state_ff == ST_RUN) && (iss_cnt_ff < n_lim_ff);
   assign done_run  = (state_ff == ST_RUN) && (recv_cnt_ff == n_lim_ff);

   // count above table size saturates
   assign n_lim_in = (active_ff > ACTIVE_W'(MAX_CHARGES)) ? CNT_W'(MAX_CHARGES)
                                                          : CNT_W'(active_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = (req_type == REQ_QUERY) ? ST_RUN : ST_FIN;
            end
         end
         ST_RUN: begin
            if (done_run) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         iso_ff      <= '0;
         active_ff   <= '0;
         n_lim_ff    <= '0;
         iss_cnt_ff  <= '0;
         recv_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_THRESHOLD:      iso_ff    <= csr_write_data;
               CSR_ACTIVE_CHARGES: active_ff <= csr_write_data[ACTIVE_W-1:0];
               default:            ;
            endcase
         end
         if (req_xfer) begin
            n_lim_ff    <= n_lim_in;
            iss_cnt_ff  <= '0;
            recv_cnt_ff <= '0;
         end else begin
            if (issue) begin
               iss_cnt_ff <= iss_cnt_ff + CNT_W'(1);
            end
            if (tail.valid) begin
               recv_cnt_ff <= recv_cnt_ff + CNT_W'(1);
            end
         end
      end
   end

   // table writes and query point capture
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         pt_x_ff <= req_pos_x;
         pt_y_ff <= req_pos_y;
         pt_z_ff <= req_pos_z;
         if (req_type == REQ_LOAD) begin
            tab_x_ff[req_slot] <= req_pos_x;
            tab_y_ff[req_slot] <= req_pos_y;
            tab_z_ff[req_slot] <= req_pos_z;
            tab_q_ff[req_slot] <= req_strength;
         end
      end
   end

   // stage 1: coordinate differences
   always_ff @(posedge clock) begin
      dx_ff   <= $signed({tab_x_ff[iss_cnt_ff[IDX_W-1:0]][COORD_W-1],
                          tab_x_ff[iss_cnt_ff[IDX_W-1:0]]})
                 - $signed({pt_x_ff[COORD_W-1], pt_x_ff});
      dy_ff   <= $signed({tab_y_ff[iss_cnt_ff[IDX_W-1:0]][COORD_W-1],
                          tab_y_ff[iss_cnt_ff[IDX_W-1:0]]})
                 - $signed({pt_y_ff[COORD_W-1], pt_y_ff});
      dz_ff   <= $signed({tab_z_ff[iss_cnt_ff[IDX_W-1:0]][COORD_W-1],
                          tab_z_ff[iss_cnt_ff[IDX_W-1:0]]})
                 - $signed({pt_z_ff[COORD_W-1], pt_z_ff});
      s1_q_ff <= $signed(tab_q_ff[iss_cnt_ff[IDX_W-1:0]]);
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= issue;
      end
   end

   // stage 2: squares
   assign px_prod = dx_ff * dx_ff;
   assign py_prod = dy_ff * dy_ff;
   assign pz_prod = dz_ff * dz_ff;

   always_ff @(posedge clock) begin
      sqx_ff  <= px_prod[SQ_W-1:0];
      sqy_ff  <= py_prod[SQ_W-1:0];
      sqz_ff  <= pz_prod[SQ_W-1:0];
      s2_q_ff <= s1_q_ff;
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else begin
         s2_v_ff <= s1_v_ff;
      end
   end

   // stage 3: squared distance and divider operands
   always_ff @(posedge clock) begin
      logic [D2_W-1:0]    d2;
      logic [COORD_W-1:0] qmag;
      d2   = D2_W'(sqx_ff) + D2_W'(sqy_ff) + D2_W'(sqz_ff);
      qmag = s2_q_ff[COORD_W-1] ? COORD_W'(-s2_q_ff) : COORD_W'(s2_q_ff);
      s3_lane_ff.neg     <= s2_q_ff[COORD_W-1];
      // zero distance saturates unless the strength is zero
      s3_lane_ff.sat     <= (d2 == '0) && (s2_q_ff != '0);
      // a zero divisor becomes one so a zero strength still gives a zero term
      s3_lane_ff.divisor <= (d2 == '0) ? D2_W'(1) : d2;
      s3_lane_ff.rem     <= '0;
      s3_lane_ff.num     <= {qmag, {COORD_W{1'b0}}};
      s3_lane_ff.quo     <= '0;
      if (reset) begin
         s3_lane_ff.valid <= 1'b0;
      end else begin
         s3_lane_ff.valid <= s2_v_ff;
      end
   end

   assign lanes[0] = s3_lane_ff;

   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      mbfp_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .lane_in  (lanes[g]),
         .lane_out (lanes[g+1])
      );
   end

   assign tail = lanes[NUM_CELLS];

   // signed term from the finished quotient
   always_comb begin
      if (tail.sat) begin
         term = tail.neg ? -$signed(TERM_SAT) : $signed(TERM_SAT);
      end else if (tail.neg) begin
         term = -$signed(ACC_W'(tail.quo));
      end else begin
         term = $signed(ACC_W'(tail.quo));
      end
   end

   // accumulate terms, clamp at the end of a query
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         acc_ff       <= -$signed({{(ACC_W-ISO_W){iso_ff[ISO_W-1]}}, iso_ff});
         res_field_ff <= '0;
         res_query_ff <= 1'b0;
         res_clamp_ff <= 1'b0;
      end else if (tail.valid) begin
         acc_ff <= acc_ff + term;
      end else if (done_run) begin
         res_query_ff <= 1'b1;
         if (acc_ff > $signed(CLAMP_Q12)) begin
            res_field_ff <= FIELD_W'(CLAMP_Q12);
            res_clamp_ff <= 1'b1;
         end else if (acc_ff < -$signed(CLAMP_Q12)) begin
            res_field_ff <= FIELD_W'(-$signed(CLAMP_Q12));
            res_clamp_ff <= 1'b1;
         end else begin
            res_field_ff <= acc_ff[FIELD_W-1:0];
            res_clamp_ff <= 1'b0;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if ((state_ff == ST_FIN) && rsp_free) begin
         rsp_field_ff <= res_field_ff;
         rsp_query_ff <= res_query_ff;
         rsp_clamp_ff <= res_clamp_ff;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_FIN) && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_field_value     = rsp_field_ff;
   assign rsp_is_query_result = rsp_query_ff;
   assign rsp_clamped         = rsp_clamp_ff;

   // no term is in flight outside a query
   a_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_RUN) |-> (!s1_v_ff && !s2_v_ff && !s3_lane_ff.valid && !tail.valid))
      else $error("term in flight outside a query");

   // terms never come back faster than they were issued
   a_recv_le_issue: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (recv_cnt_ff <= iss_cnt_ff))
      else $error("more terms received than issued");

   // a clamped answer sits exactly on the clamp
   a_clamp_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_clamp_ff) |->
         (rsp_field_ff == FIELD_W'(CLAMP_Q12) ||
          rsp_field_ff == FIELD_W'(-$signed(CLAMP_Q12))))
      else $error("clamped result off the clamp value");

   // a load acknowledgement is all zero
   a_load_ack: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_query_ff) |-> (rsp_field_ff == '0 && !rsp_clamp_ff))
      else $error("load acknowledgement not zero");

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// self-checking testbench for the metaball field potential block
`default_nettype none

module tb_top;
   import mbfp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // clock period in ns, and a generous end for the whole run
   localparam int  CLK_PERIOD   = 4;
   localparam int  RESET_CYCLES = 7;
   localparam time RUN_LIMIT    = 8ms;
   localparam int  TAIL_CYCLES  = 60;

   localparam longint CLAMP_LIM = 64'sd409600000000;
   localparam longint TERM_LIM  = 64'sd72057594037927936;
   localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7fffff;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

   // kinds of rows in the directed stimulus table
   typedef enum logic [1:0] {ROW_LOAD, ROW_QUERY, ROW_CSR} row_kind_type;

   typedef struct {
      logic                      kind;
      logic [IDX_W-1:0]          slot;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic signed [COORD_W-1:0] strength;
   } request_type;

   typedef struct {
      logic signed [FIELD_W-1:0] field;
      logic                      is_query;
      logic                      clamped;
   } potential_type;

   typedef struct {
      row_kind_type              kind;
      request_type               req;
      logic                      csr_index;
      logic [ISO_W-1:0]          csr_data;
      bit                        typed;      // expected result typed in below
      potential_type             result;
   } plan_row_type;

   // ------------------------------------------------------------------
   // dut connections
   // ------------------------------------------------------------------
   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic                      req_type;
   logic [IDX_W-1:0]          req_slot;
   logic signed [COORD_W-1:0] req_pos_x;
   logic signed [COORD_W-1:0] req_pos_y;
   logic signed [COORD_W-1:0] req_pos_z;
   logic signed [COORD_W-1:0] req_strength;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic signed [FIELD_W-1:0] rsp_field_value;
   logic                      rsp_is_query_result;
   logic                      rsp_clamped;
   logic                      csr_write_enable;
   logic                      csr_index;
   logic [ISO_W-1:0]          csr_write_data;

   metaball_field_potential u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_type            (req_type),
      .req_slot            (req_slot),
      .req_pos_x           (req_pos_x),
      .req_pos_y           (req_pos_y),
      .req_pos_z           (req_pos_z),
      .req_strength        (req_strength),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_field_value     (rsp_field_value),
      .rsp_is_query_result (rsp_is_query_result),
      .rsp_clamped         (rsp_clamped),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   // ------------------------------------------------------------------
   // shadow of the charge table and the registers
   // ------------------------------------------------------------------
   logic signed [COORD_W-1:0] shadow_x [MAX_CHARGES];
   logic signed [COORD_W-1:0] shadow_y [MAX_CHARGES];
   logic signed [COORD_W-1:0] shadow_z [MAX_CHARGES];
   logic signed [COORD_W-1:0] shadow_q [MAX_CHARGES];
   logic signed [ISO_W-1:0]   shadow_iso;
   logic [ACTIVE_W-1:0]       shadow_active;

   potential_type pending_fields[$];   // expected results, oldest first
   int            mismatch_count;

   // one charge's contribution: (q << 24) / d2, truncated toward zero
   function automatic longint charge_term(longint q, longint unsigned d2);
      longint unsigned mag;
      longint unsigned quo;
      if (q == 0) return 0;
      // coincident point saturates by the sign of the charge
      if (d2 == 0) return (q > 0) ? TERM_LIM : -TERM_LIM;
      mag = longint'((q < 0) ? -q : q) << 24;
      quo = mag / d2;
      return (q < 0) ? -longint'(quo) : longint'(quo);
   endfunction

   // works out the response of one request and applies a load to the shadow
   function automatic potential_type field_at(request_type r);
      potential_type res;
      longint        acc;
      longint        dx, dy, dz;
      int            n;
      res = '{field: '0, is_query: 1'b0, clamped: 1'b0};
      if (r.kind == REQ_LOAD) begin
         shadow_x[r.slot] = r.x;
         shadow_y[r.slot] = r.y;
         shadow_z[r.slot] = r.z;
         shadow_q[r.slot] = r.strength;
         return res;
      end
      // counts beyond the table use the whole table
      n   = (shadow_active > MAX_CHARGES) ? MAX_CHARGES : int'(shadow_active);
      acc = -longint'(shadow_iso);
      for (int i = 0; i < n; i++) begin
         dx  = longint'(shadow_x[i]) - longint'(r.x);
         dy  = longint'(shadow_y[i]) - longint'(r.y);
         dz  = longint'(shadow_z[i]) - longint'(r.z);
         acc += charge_term(longint'(shadow_q[i]), longint'(dx*dx + dy*dy + dz*dz));
      end
      res.is_query = 1'b1;
      if (acc > CLAMP_LIM) begin
         acc = CLAMP_LIM;
         res.clamped = 1'b1;
      end else if (acc < -CLAMP_LIM) begin
         acc = -CLAMP_LIM;
         res.clamped = 1'b1;
      end
      res.field = FIELD_W'(acc);
      return res;
   endfunction

   // ------------------------------------------------------------------
   // clock, reset and run limit
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2.0) clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   // ------------------------------------------------------------------
   // receiver: stalls on its own pattern, redrawn at random from four kinds on a counter of clock cycles
   // ------------------------------------------------------------------
   int stall_mode;
   int stall_age;

   initial begin
      rsp_stall  = 1'b0;
      stall_mode = 0;
      stall_age  = 0;
      forever begin
         @(negedge clock);
         stall_age++;
         if (stall_age >= 150) begin
            stall_age  = 0;
            stall_mode = $urandom_range(0, 3);
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;                           // stretch with no stall
            1: rsp_stall <= ($urandom_range(0, 9) < 3);     // light random stall
            2: rsp_stall <= ($urandom_range(0, 9) < 8);     // heavy random stall
            default: rsp_stall <= (stall_age % 7) < 3;      // periodic stall
         endcase
      end
   end

   // ------------------------------------------------------------------
   // result checker: each transfer against the oldest expectation
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      potential_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_fields.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result transfer: field %0d query %0b clamped %0b",
                        rsp_field_value, rsp_is_query_result, rsp_clamped);
         end else begin
            want = pending_fields.pop_front();
            if (rsp_field_value !== want.field || rsp_is_query_result !== want.is_query
                || rsp_clamped !== want.clamped) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch at %0t: field %0d/%0d query %0b/%0b clamped %0b/%0b",
                           $realtime, rsp_field_value, want.field, rsp_is_query_result,
                           want.is_query, rsp_clamped, want.clamped);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // sender side
   // ------------------------------------------------------------------
   int burst_left;

   // one request transfer; the expectation is logged at the accepting edge
   task automatic send_request(request_type r, bit typed, potential_type typed_res);
      potential_type predicted;
      // bursts of random length with random gaps in between
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 3) != 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid    <= 1'b1;
      req_type     <= r.kind;
      req_slot     <= r.slot;
      req_pos_x    <= r.x;
      req_pos_y    <= r.y;
      req_pos_z    <= r.z;
      req_strength <= r.strength;
      do @(posedge clock); while (req_stall);
      predicted = field_at(r);
      pending_fields.push_back(typed ? typed_res : predicted);
   endtask

   // waits until every expected result has come back
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_fields.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // register write, only done with the block idle
   task automatic write_csr(logic index, logic [ISO_W-1:0] data);
      drain_results();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (index == CSR_THRESHOLD) shadow_iso = data;
      else shadow_active = data[ACTIVE_W-1:0];
   endtask

   function automatic logic signed [COORD_W-1:0] pick_coord();
      case ($urandom_range(0, 9))
         0: return COORD_MAX;
         1: return COORD_MIN;
         2: return COORD_W'($urandom_range(0, 8192)) - 24'sd4096;
         default: return COORD_W'($urandom);
      endcase
   endfunction

   function automatic request_type random_load();
      request_type r;
      r.kind     = REQ_LOAD;
      r.slot     = IDX_W'($urandom);
      r.x        = pick_coord();
      r.y        = pick_coord();
      r.z        = pick_coord();
      r.strength = ($urandom_range(0, 7) == 0) ? '0 : pick_coord();
      return r;
   endfunction

   // query point: on a charge, close to one, or anywhere
   function automatic request_type random_query();
      request_type r;
      int          k;
      r      = random_load();
      r.kind = REQ_QUERY;
      k      = $urandom_range(0, MAX_CHARGES - 1);
      case ($urandom_range(0, 5))
         0: begin
            r.x = shadow_x[k];
            r.y = shadow_y[k];
            r.z = shadow_z[k];
         end
         1, 2: begin
            r.x = shadow_x[k] + COORD_W'($urandom_range(0, 512)) - 24'sd256;
            r.y = shadow_y[k] + COORD_W'($urandom_range(0, 512)) - 24'sd256;
            r.z = shadow_z[k] + COORD_W'($urandom_range(0, 512)) - 24'sd256;
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic plan_row_type load_row(int slot, logic signed [COORD_W-1:0] x,
                                             logic signed [COORD_W-1:0] y,
                                             logic signed [COORD_W-1:0] z,
                                             logic signed [COORD_W-1:0] q);
      plan_row_type p;
      p.kind   = ROW_LOAD;
      p.req    = '{REQ_LOAD, IDX_W'(slot), x, y, z, q};
      p.typed  = 1'b1;                        // load ack is always all zero
      p.result = '{field: '0, is_query: 1'b0, clamped: 1'b0};
      return p;
   endfunction

   function automatic plan_row_type query_row(logic signed [COORD_W-1:0] x,
                                              logic signed [COORD_W-1:0] y,
                                              logic signed [COORD_W-1:0] z);
      plan_row_type p;
      p.kind   = ROW_QUERY;
      p.req    = '{REQ_QUERY, '1, x, y, z, COORD_MIN};
      p.typed  = 1'b0;
      p.result = '{field: '0, is_query: 1'b1, clamped: 1'b0};
      return p;
   endfunction

   function automatic plan_row_type csr_row(logic index, logic [ISO_W-1:0] data);
      plan_row_type p;
      p           = query_row('0, '0, '0);
      p.kind      = ROW_CSR;
      p.csr_index = index;
      p.csr_data  = data;
      return p;
   endfunction

   // typed expectation on a query row
   function automatic plan_row_type with_result(plan_row_type p, longint v, logic clip);
      p.typed  = 1'b1;
      p.result = '{field: FIELD_W'(v), is_query: 1'b1, clamped: clip};
      return p;
   endfunction

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   plan_row_type plan[$];

   initial begin
      request_type r;
      int          n_items;
      logic [ISO_W-1:0] iso_pick;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_type         = REQ_LOAD;
      req_slot         = '0;
      req_pos_x        = '0;
      req_pos_y        = '0;
      req_pos_z        = '0;
      req_strength     = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_THRESHOLD;
      csr_write_data   = '0;
      shadow_iso       = '0;
      shadow_active    = '0;
      mismatch_count   = 0;
      burst_left       = 0;
      for (int i = 0; i < MAX_CHARGES; i++) begin
         shadow_x[i] = '0;
         shadow_y[i] = '0;
         shadow_z[i] = '0;
         shadow_q[i] = '0;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part: no charges, extremes, coincident points, threshold extremes
      plan.push_back(with_result(query_row(COORD_MAX, COORD_MIN, '0), 0, 1'b0));
      plan.push_back(load_row(0, '0, '0, '0, COORD_MAX));
      plan.push_back(load_row(1, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN));
      plan.push_back(load_row(2, 24'sd5, 24'sd5, 24'sd5, '0));
      plan.push_back(csr_row(CSR_ACTIVE_CHARGES, 32'd1));
      plan.push_back(with_result(query_row('0, '0, '0), CLAMP_LIM, 1'b1));
      plan.push_back(query_row(COORD_MIN, COORD_MIN, COORD_MIN));
      plan.push_back(csr_row(CSR_ACTIVE_CHARGES, 32'd2));
      plan.push_back(with_result(query_row(COORD_MAX, COORD_MAX, COORD_MAX),
                                 -CLAMP_LIM, 1'b1));
      plan.push_back(csr_row(CSR_ACTIVE_CHARGES, 32'd3));
      plan.push_back(query_row(24'sd5, 24'sd5, 24'sd5));     // zero charge on the point
      plan.push_back(csr_row(CSR_THRESHOLD, 32'h7fffffff));
      plan.push_back(query_row(24'sd4096, COORD_MIN, 24'sd100));
      plan.push_back(csr_row(CSR_THRESHOLD, 32'h80000000));
      plan.push_back(query_row(COORD_MIN, 24'sd4096, COORD_MAX));
      plan.push_back(query_row(24'sd6, 24'sd5, 24'sd5));

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) write_csr(plan[i].csr_index, plan[i].csr_data);
         else send_request(plan[i].req, plan[i].typed, plan[i].result);
      end

      // fill the whole table before any count can reach unwritten entries
      for (int i = 0; i < MAX_CHARGES; i++) begin
         r      = random_load();
         r.slot = IDX_W'(i);
         send_request(r, 1'b0, '{default: '0});
      end

      // random phases, each under its own register setting
      n_items = 0;
      for (int phase = 0; n_items < 600; phase++) begin
         case (phase % 4)
            0: iso_pick = 32'h80000000;
            1: iso_pick = 32'h7fffffff;
            2: iso_pick = '0;
            default: iso_pick = $urandom;
         endcase
         write_csr(CSR_THRESHOLD, iso_pick);
         case (phase % 5)
            0: write_csr(CSR_ACTIVE_CHARGES, 32'd16);
            1: write_csr(CSR_ACTIVE_CHARGES, 32'd0);
            2: write_csr(CSR_ACTIVE_CHARGES, 32'd31);   // saturates to the table size
            default: write_csr(CSR_ACTIVE_CHARGES, ISO_W'($urandom_range(1, 31)));
         endcase
         repeat ($urandom_range(30, 70)) begin
            if ($urandom_range(0, 9) < 3) send_request(random_load(), 1'b0, '{default: '0});
            else send_request(random_query(), 1'b0, '{default: '0});
            n_items++;
         end
      end

      // wait out the tail, then judge
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_fields.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
